// ===== design/gn3d_pkg.sv =====
// Shared constants and arithmetic helpers for the 3D gradient noise block.
package gn3d_pkg;

    localparam int TABLE_SIZE = 256;
    localparam int TBL_AW     = $clog2(TABLE_SIZE);
    localparam int FRAC_BITS  = 16;
    localparam int ONE        = 1 << FRAC_BITS;
    localparam int COORD_W    = 32;
    localparam int OUT_W      = 18;
    localparam int OUT_MAX    = 65536;

    // Signed widths: fraction with offset, gradient dot product, fade weight
    localparam int FR_W = FRAC_BITS + 2;
    localparam int GR_W = FRAC_BITS + 4;
    localparam int WT_W = FRAC_BITS + 2;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    typedef logic [TBL_AW-1:0]           addr_t;
    typedef logic [7:0]                  perm_t;
    typedef logic [FRAC_BITS-1:0]        frac_t;
    typedef logic signed [FR_W-1:0]      sfrac_t;
    typedef logic signed [GR_W-1:0]      grad_t;
    typedef logic signed [WT_W-1:0]      wt_t;

    // Gradient dot product selected by the low four hash bits
    function automatic grad_t grad(input perm_t hash, input sfrac_t x,
                                   input sfrac_t y, input sfrac_t z);
        logic [3:0] h;
        grad_t      u;
        grad_t      v;
        h = hash[3:0];
        u = (h < 4'd8) ? grad_t'(x) : grad_t'(y);
        if (h < 4'd4)
            v = grad_t'(y);
        else if (h == 4'd12 || h == 4'd14)
            v = grad_t'(x);
        else
            v = grad_t'(z);
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    // Linear blend p + floor(w*(q-p) / ONE)
    function automatic grad_t lerp(input wt_t w, input grad_t p, input grad_t q);
        logic signed [GR_W:0]          diff;
        logic signed [GR_W+WT_W:0]     prod;
        diff = (GR_W+1)'(q) - (GR_W+1)'(p);
        prod = (GR_W+WT_W+1)'(w) * (GR_W+WT_W+1)'(diff);
        return p + GR_W'(prod >>> FRAC_BITS);
    endfunction

endpackage

// ===== design/gradient_noise_3d_top.sv =====
// Top level: pipelined 3D gradient noise evaluator with replicated permutation tables.
// An accepted evaluate transaction's result passes through the pipeline stage registers and the output register.
// Throughput: one transaction per cycle unless m_axis_tready stalls the output; each table
// level reads its own dual-read copies, so the three hash levels and the fade/blend stages overlap fully.
// Load transactions ripple through the table copies in order and give no result.
// Reset clears pipeline and output valid bits; table contents are undefined until loaded.
module gradient_noise_3d_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // table_index[7:0], table_value[15:8], coord_x[47:16], coord_y[79:48], coord_z[111:80]
    input  logic [111:0] s_axis_tdata,
    // mode[0]
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // noise_value[17:0], zero pad [23:18]
    output logic [23:0]  m_axis_tdata
);
    import gn3d_pkg::*;

    // Table copies: level one, level two (two copies), level three (four copies)
    perm_t mem1  [TABLE_SIZE];
    perm_t mem2a [TABLE_SIZE];
    perm_t mem2b [TABLE_SIZE];
    perm_t mem3a [TABLE_SIZE];
    perm_t mem3b [TABLE_SIZE];
    perm_t mem3c [TABLE_SIZE];
    perm_t mem3d [TABLE_SIZE];

    logic adv;
    logic out_vld_reg;
    logic signed [OUT_W-1:0] out_data_reg;

    assign adv           = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {6'd0, out_data_reg};

    // Input unpack
    logic  in_acc;
    addr_t in_idx;
    perm_t in_val;
    logic [COORD_W-1:0] in_c [3];
    addr_t in_cell [3];
    frac_t in_frac [3];

    assign in_acc  = s_axis_tvalid && adv;
    assign in_idx  = s_axis_tdata[TBL_AW-1:0];
    assign in_val  = s_axis_tdata[15:8];
    assign in_c[0] = s_axis_tdata[47:16];
    assign in_c[1] = s_axis_tdata[79:48];
    assign in_c[2] = s_axis_tdata[111:80];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            in_cell[k] = in_c[k][FRAC_BITS +: TBL_AW];
            in_frac[k] = in_c[k][FRAC_BITS-1:0];
        end
    end

    // Pipeline valid and mode bits
    logic [7:1] vld_reg;
    logic [7:1] mode_reg;

    // Stage payloads
    addr_t idx1_reg, idx2_reg;
    perm_t val1_reg, val2_reg;
    addr_t cy1_reg, cz1_reg, cz2_reg;
    frac_t fr1_reg [3];
    frac_t fr2_reg [3];
    frac_t fr3_reg [3];
    perm_t rd1_reg [2];
    perm_t rd2_reg [4];
    perm_t hash3_reg [8];

    // Fade pipeline
    logic signed [37:0] ta1_reg [3];
    logic [31:0]        tt1_reg [3];
    logic signed [20:0] fb2_reg [3];
    logic [31:0]        p32_reg [3];
    logic signed [37:0] p43_reg [3];
    wt_t                fade4_reg [3];
    wt_t                v5_reg, w5_reg, w6_reg;

    grad_t g4_reg [8];
    grad_t l5_reg [4];
    grad_t l6_reg [2];
    grad_t r7_reg;

    // Combinational per-stage values
    logic signed [20:0] sa_next [3];
    logic signed [37:0] ta_next [3];
    logic signed [20:0] fb_next [3];
    logic [31:0]        p3_next [3];
    logic signed [37:0] p4_next [3];
    addr_t a_next, b_next;
    addr_t aa_next, ab_next, ba_next, bb_next;
    sfrac_t px [2];
    sfrac_t py [2];
    sfrac_t pz [2];
    grad_t  g_next [8];
    grad_t  sat_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sa_next[k] = $signed({5'd0, in_frac[k]}) * 21'sd6 - 21'sd983040;
            ta_next[k] = 38'($signed({1'b0, in_frac[k]})) * 38'(sa_next[k]);
            fb_next[k] = 21'(ta1_reg[k] >>> FRAC_BITS) + 21'sd655360;
            p3_next[k] = 32'(tt1_reg[k][31:16]) * 32'(fr1_reg[k]);
            p4_next[k] = 38'($signed({1'b0, p32_reg[k][31:16]})) * 38'(fb2_reg[k]);
        end
        a_next  = addr_t'(rd1_reg[0]) + cy1_reg;
        b_next  = addr_t'(rd1_reg[1]) + cy1_reg;
        aa_next = addr_t'(rd2_reg[0]) + cz2_reg;
        ab_next = addr_t'(rd2_reg[1]) + cz2_reg;
        ba_next = addr_t'(rd2_reg[2]) + cz2_reg;
        bb_next = addr_t'(rd2_reg[3]) + cz2_reg;
        px[0] = sfrac_t'({2'b00, fr3_reg[0]});
        py[0] = sfrac_t'({2'b00, fr3_reg[1]});
        pz[0] = sfrac_t'({2'b00, fr3_reg[2]});
        px[1] = px[0] - sfrac_t'(ONE);
        py[1] = py[0] - sfrac_t'(ONE);
        pz[1] = pz[0] - sfrac_t'(ONE);
        for (int i = 0; i < 8; i++)
            g_next[i] = grad(hash3_reg[i], px[i % 2], py[(i / 2) % 2], pz[i / 4]);
        if (r7_reg > grad_t'(OUT_MAX))
            sat_next = grad_t'(OUT_MAX);
        else if (r7_reg < -grad_t'(OUT_MAX))
            sat_next = -grad_t'(OUT_MAX);
        else
            sat_next = r7_reg;
    end

    // Control: valid bits and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[6:1], in_acc};
            out_vld_reg <= vld_reg[7] && (mode_reg[7] == MODE_EVAL);
        end
    end

    // Level one table: load write and two corner reads
    always_ff @(posedge clk)
    begin
        if (in_acc && s_axis_tuser == MODE_LOAD)
            mem1[in_idx] <= in_val;
        if (adv)
        begin
            rd1_reg[0] <= mem1[in_cell[0]];
            rd1_reg[1] <= mem1[in_cell[0] + addr_t'(1)];
        end
    end

    // Level two copies: write in pipeline order, read a, a+1, b, b+1
    always_ff @(posedge clk)
    begin
        if (adv && vld_reg[1] && mode_reg[1] == MODE_LOAD)
        begin
            mem2a[idx1_reg] <= val1_reg;
            mem2b[idx1_reg] <= val1_reg;
        end
        if (adv)
        begin
            rd2_reg[0] <= mem2a[a_next];
            rd2_reg[1] <= mem2a[a_next + addr_t'(1)];
            rd2_reg[2] <= mem2b[b_next];
            rd2_reg[3] <= mem2b[b_next + addr_t'(1)];
        end
    end

    // Level three copies: corner hashes in gradient order
    always_ff @(posedge clk)
    begin
        if (adv && vld_reg[2] && mode_reg[2] == MODE_LOAD)
        begin
            mem3a[idx2_reg] <= val2_reg;
            mem3b[idx2_reg] <= val2_reg;
            mem3c[idx2_reg] <= val2_reg;
            mem3d[idx2_reg] <= val2_reg;
        end
        if (adv)
        begin
            hash3_reg[0] <= mem3a[aa_next];
            hash3_reg[4] <= mem3a[aa_next + addr_t'(1)];
            hash3_reg[1] <= mem3b[ba_next];
            hash3_reg[5] <= mem3b[ba_next + addr_t'(1)];
            hash3_reg[2] <= mem3c[ab_next];
            hash3_reg[6] <= mem3c[ab_next + addr_t'(1)];
            hash3_reg[3] <= mem3d[bb_next];
            hash3_reg[7] <= mem3d[bb_next + addr_t'(1)];
        end
    end

    // Advance payload, fade and blend stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mode_reg <= {mode_reg[6:1], s_axis_tuser};
            idx1_reg <= in_idx;
            val1_reg <= in_val;
            idx2_reg <= idx1_reg;
            val2_reg <= val1_reg;
            cy1_reg  <= in_cell[1];
            cz1_reg  <= in_cell[2];
            cz2_reg  <= cz1_reg;
            for (int k = 0; k < 3; k++)
            begin
                fr1_reg[k]   <= in_frac[k];
                fr2_reg[k]   <= fr1_reg[k];
                fr3_reg[k]   <= fr2_reg[k];
                ta1_reg[k]   <= ta_next[k];
                tt1_reg[k]   <= 32'(in_frac[k]) * 32'(in_frac[k]);
                fb2_reg[k]   <= fb_next[k];
                p32_reg[k]   <= p3_next[k];
                p43_reg[k]   <= p4_next[k];
                fade4_reg[k] <= wt_t'(p43_reg[k] >>> FRAC_BITS);
            end
            for (int i = 0; i < 8; i++)
                g4_reg[i] <= g_next[i];
            v5_reg <= fade4_reg[1];
            w5_reg <= fade4_reg[2];
            w6_reg <= w5_reg;
            for (int i = 0; i < 4; i++)
                l5_reg[i] <= lerp(fade4_reg[0], g4_reg[2*i], g4_reg[2*i+1]);
            l6_reg[0]    <= lerp(v5_reg, l5_reg[0], l5_reg[1]);
            l6_reg[1]    <= lerp(v5_reg, l5_reg[2], l5_reg[3]);
            r7_reg       <= lerp(w6_reg, l6_reg[0], l6_reg[1]);
            out_data_reg <= OUT_W'(sat_next);
        end
    end

endmodule
